// File: design/fbc_pkg.sv
// shared types and constants for the frustum box cull test
// no dependencies; used by fbc_regs, fbc_cell and frustum_box_cull_test
package fbc_pkg;

    localparam int COORD_W            = 24;
    localparam int NORM_W             = 12;
    localparam int OFS_W              = 28;
    localparam int PLANE_W            = 64;
    localparam int PLANE_REGS         = 6;
    localparam int IDX_W              = 3;
    localparam int ADDR_W             = 6;
    localparam int DEFAULT_NUM_PLANES = 6;

    // offset d is Q.8, products are Q.18
    localparam int D_SHIFT = 10;

    // product of a normal and a coordinate, a sum of three, the distance
    // with the offset added, and the final compare sum
    localparam int PROD_W = NORM_W + COORD_W;
    localparam int DOT_W  = PROD_W + 2;
    localparam int DIST_W = DOT_W + 2;
    localparam int CMP_W  = DIST_W + 1;

    typedef struct packed {
        logic signed [OFS_W-1:0]  d;
        logic signed [NORM_W-1:0] c;
        logic signed [NORM_W-1:0] b;
        logic signed [NORM_W-1:0] a;
    } t_plane;

    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } t_vec;

    // entry 0 is the center, entries 1 to 3 the scaled half-axes
    typedef struct packed {
        t_vec [3:0] v;
    } t_box;

    typedef struct packed {
        logic valid;
        logic visible;
    } t_tag;

endpackage

// File: design/fbc_regs.sv
// plane register file behind the apb-style configuration port
// depends on fbc_pkg
module fbc_regs (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            psel,
    input  logic                                            penable,
    input  logic                                            pwrite,
    input  logic [fbc_pkg::ADDR_W-1:0]                      paddr,
    input  logic [fbc_pkg::PLANE_W-1:0]                     pwdata,
    output logic [fbc_pkg::PLANE_W-1:0]                     prdata,
    output logic                                            pready,
    output fbc_pkg::t_plane [fbc_pkg::PLANE_REGS-1:0]       o_planes
);

    localparam logic [fbc_pkg::IDX_W-1:0] LAST_IDX =
        fbc_pkg::IDX_W'(fbc_pkg::PLANE_REGS - 1);

    logic [fbc_pkg::PLANE_W-1:0] r_plane [fbc_pkg::PLANE_REGS];
    logic [fbc_pkg::IDX_W-1:0]   w_idx;
    logic                        w_hit;

    assign w_idx  = paddr[fbc_pkg::ADDR_W-1:3];
    assign w_hit  = (w_idx <= LAST_IDX);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < fbc_pkg::PLANE_REGS; i++) begin
                r_plane[i] <= '0;
            end
        end else if (psel && penable && pwrite && w_hit) begin
            r_plane[w_idx] <= pwdata;
        end
    end

    always_comb begin
        prdata = '0;
        if (w_hit) begin
            prdata = r_plane[w_idx];
        end
    end

    always_comb begin
        for (int i = 0; i < fbc_pkg::PLANE_REGS; i++) begin
            o_planes[i] = fbc_pkg::t_plane'(r_plane[i]);
        end
    end

endmodule

// File: design/fbc_cell.sv
// one plane test cell: products, dot sums, then the reject compare
// the box moves on one cell per cycle while i_en is high; the verdict trails
// it through the r_prod and r_dist/r_dot registers; depends on fbc_pkg
module fbc_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  fbc_pkg::t_plane i_plane,
    input  fbc_pkg::t_box   i_box,
    input  fbc_pkg::t_tag   i_tag,
    output fbc_pkg::t_box   o_box,
    output fbc_pkg::t_tag   o_tag
);

    localparam int PW = fbc_pkg::PROD_W;
    localparam int DW = fbc_pkg::DOT_W;
    localparam int SW = fbc_pkg::DIST_W;
    localparam int CW = fbc_pkg::CMP_W;

    fbc_pkg::t_box        r_box;
    logic signed [PW-1:0] r_prod [4][3];
    logic signed [PW-1:0] n_prod [4][3];
    logic signed [SW-1:0] r_dist;
    logic signed [SW-1:0] n_dist;
    logic signed [DW-1:0] r_dot [3];
    logic signed [DW-1:0] n_dot [3];
    logic signed [CW-1:0] n_sum;
    logic                 n_reject;
    fbc_pkg::t_tag        r_tag;

    // stage 1: normal times every vector of the box
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            n_prod[j][0] = PW'(i_plane.a) * PW'(i_box.v[j].x);
            n_prod[j][1] = PW'(i_plane.b) * PW'(i_box.v[j].y);
            n_prod[j][2] = PW'(i_plane.c) * PW'(i_box.v[j].z);
        end
    end

    // stage 2: center distance with the offset, and the three axis dots
    always_comb begin
        n_dist = SW'(r_prod[0][0]) + SW'(r_prod[0][1]) + SW'(r_prod[0][2])
               + (SW'(i_plane.d) <<< fbc_pkg::D_SHIFT);
        for (int j = 0; j < 3; j++) begin
            n_dot[j] = DW'(r_prod[j+1][0]) + DW'(r_prod[j+1][1])
                     + DW'(r_prod[j+1][2]);
        end
    end

    // stage 3: dist <= -rad is the same as dist + rad <= 0
    always_comb begin
        n_sum = CW'(r_dist);
        for (int j = 0; j < 3; j++) begin
            n_sum = n_sum + (r_dot[j][DW-1] ? -CW'(r_dot[j]) : CW'(r_dot[j]));
        end
        n_reject = n_sum[CW-1] || (n_sum == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else if (i_en) begin
            r_tag.valid   <= i_tag.valid;
            r_tag.visible <= i_tag.visible && !n_reject;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_box  <= i_box;
            r_prod <= n_prod;
            r_dist <= n_dist;
            r_dot  <= n_dot;
        end
    end

    assign o_box = r_box;
    assign o_tag = r_tag;

endmodule

// File: design/frustum_box_cull_test.sv
// oriented box frustum cull test: top level with the cell chain and output skid
// depends on fbc_pkg, fbc_regs and fbc_cell
//
// usage:
//   the input channel carries one box per transaction (center and three scaled
//   half-axes, Q16.8); the output channel returns one visible bit per box, in
//   order. both channels use valid/stall; a transaction happens on a rising
//   edge with valid high and stall low.
//   planes are written through the apb-style port at byte address 8*i; write
//   them only while no box is in flight.
//   chain: the box walks a chain of one cell per active plane, one cell
//   per cycle while not held; each cell spends three stages on multiply,
//   sum and compare, and the last cell's verdict then goes into the output
//   register (NUM_PLANES capped at six).
//   throughput: one box per cycle unless o_stall holds the cell chain.
//   when the receiver stalls, a two-entry output stage (output register plus
//   skid) keeps taking results; only when both are full does o_stall rise and
//   the whole chain hold.
//   reset clears all planes to zero, so every box is culled until planes are
//   written, and empties the chain and output stage.
module frustum_box_cull_test #(
    parameter int NUM_PLANES = fbc_pkg::DEFAULT_NUM_PLANES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [fbc_pkg::COORD_W-1:0]  i_center_x,
    input  logic signed [fbc_pkg::COORD_W-1:0]  i_center_y,
    input  logic signed [fbc_pkg::COORD_W-1:0]  i_center_z,
    input  logic signed [fbc_pkg::COORD_W-1:0]  i_axis0_x,
    input  logic signed [fbc_pkg::COORD_W-1:0]  i_axis0_y,
    input  logic signed [fbc_pkg::COORD_W-1:0]  i_axis0_z,
    input  logic signed [fbc_pkg::COORD_W-1:0]  i_axis1_x,
    input  logic signed [fbc_pkg::COORD_W-1:0]  i_axis1_y,
    input  logic signed [fbc_pkg::COORD_W-1:0]  i_axis1_z,
    input  logic signed [fbc_pkg::COORD_W-1:0]  i_axis2_x,
    input  logic signed [fbc_pkg::COORD_W-1:0]  i_axis2_y,
    input  logic signed [fbc_pkg::COORD_W-1:0]  i_axis2_z,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_visible,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fbc_pkg::ADDR_W-1:0]          paddr,
    input  logic [fbc_pkg::PLANE_W-1:0]         pwdata,
    output logic [fbc_pkg::PLANE_W-1:0]         prdata,
    output logic                                pready
);

    localparam int NCELL = (NUM_PLANES < fbc_pkg::PLANE_REGS) ? NUM_PLANES
                                                              : fbc_pkg::PLANE_REGS;

    fbc_pkg::t_plane [fbc_pkg::PLANE_REGS-1:0] w_planes;
    fbc_pkg::t_box                             w_box [NCELL+1];
    fbc_pkg::t_tag                             w_tag [NCELL+1];

    logic       w_en;
    logic [1:0] r_vld_dly;
    logic       r_out_v;
    logic       r_out_vis;
    logic       r_skid_v;
    logic       r_skid_vis;

    fbc_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_planes (w_planes)
    );

    // chain holds only when both output entries are full
    assign w_en    = !r_skid_v;
    assign o_stall = r_skid_v;

    assign w_box[0].v[0] = '{z: i_center_z, y: i_center_y, x: i_center_x};
    assign w_box[0].v[1] = '{z: i_axis0_z,  y: i_axis0_y,  x: i_axis0_x};
    assign w_box[0].v[2] = '{z: i_axis1_z,  y: i_axis1_y,  x: i_axis1_x};
    assign w_box[0].v[3] = '{z: i_axis2_z,  y: i_axis2_y,  x: i_axis2_x};

    // the first cell's verdict input trails its box through the two r_vld_dly registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_dly <= '0;
        end else if (w_en) begin
            r_vld_dly <= {r_vld_dly[0], i_valid};
        end
    end

    assign w_tag[0].valid   = r_vld_dly[1];
    assign w_tag[0].visible = 1'b1;

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        fbc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_plane (w_planes[k]),
            .i_box   (w_box[k]),
            .i_tag   (w_tag[k]),
            .o_box   (w_box[k+1]),
            .o_tag   (w_tag[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (!i_stall) begin
                r_out_vis <= r_skid_vis;
                r_skid_v  <= 1'b0;
            end
        end else if (w_tag[NCELL].valid) begin
            if (!r_out_v || !i_stall) begin
                r_out_v   <= 1'b1;
                r_out_vis <= w_tag[NCELL].visible;
            end else begin
                r_skid_v   <= 1'b1;
                r_skid_vis <= w_tag[NCELL].visible;
            end
        end else if (!i_stall) begin
            r_out_v <= 1'b0;
        end
    end

    assign o_valid   = r_out_v;
    assign o_visible = r_out_vis;

`ifndef SYNTH
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry held without an output entry");

    a_skid_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && i_stall))
        else $error("skid filled while the output register was free");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && i_stall) |=> r_skid_v)
        else $error("skid entry lost while the receiver stalled");
`endif

endmodule
